// File: design/sba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_pkg - shared types and constants of the slot bitmap allocator
// Command and status codes, sequencer states and the scan unit's status word.
// ----------------------------------------------------------------------------
package sba_pkg;

	// Default pool size and fixed field widths
	localparam int SLOTS_DEF  = 256;
	localparam int ID_W       = 10;
	localparam int STAMP_W    = 32;
	localparam int SLOT_OUT_W = 8;
	localparam int CNT_OUT_W  = 9;

	// Bitmap bits looked at by the scan unit in one cycle (power of two)
	localparam int SCAN_W     = 32;

	typedef enum logic [1:0] {
		CMD_ALLOC_NEXT = 2'd0,
		CMD_ALLOC_ID   = 2'd1,
		CMD_RELEASE    = 2'd2,
		CMD_INSPECT    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_RANGE     = 2'd2,
		STAT_BAD_STATE = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_EXEC
	} state_t;

	// Scan unit status toward the sequencer
	typedef struct packed {
		logic hit;   // current window holds a free slot
		logic last;  // current window is the final one
	} scan_t;

endpackage : sba_pkg
`default_nettype wire

// File: design/sba_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_scan - first-fit search over the free bitmap
// Walks the bitmap one window per cycle and encodes the lowest free slot.
// ----------------------------------------------------------------------------
module sba_scan #(
	parameter int SLOTS = sba_pkg::SLOTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clear,
	input  wire logic                     step,
	input  wire logic [SLOTS-1:0]         free_map,
	output sba_pkg::scan_t                res,
	output logic      [$clog2(SLOTS)-1:0] idx
);
	import sba_pkg::*;

	localparam int IW  = $clog2(SLOTS);
	localparam int NCH = (SLOTS + SCAN_W - 1) / SCAN_W;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PW  = NCH * SCAN_W;
	localparam int PEW = $clog2(SCAN_W);

	logic [CHW-1:0]    chunk_q;
	logic [PW-1:0]     pad_map;
	logic [SCAN_W-1:0] win;
	logic [PEW-1:0]    pe;

	// Pad past the pool with zeros so those bits never read as free
	assign pad_map = PW'(free_map);
	assign win     = pad_map[chunk_q*SCAN_W +: SCAN_W];

	// Encode the lowest set bit of the window
	always_comb begin
		pe = '0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (win[i]) begin
				pe = PEW'(i);
			end
		end
	end

	assign res.hit  = |win;
	assign res.last = (chunk_q == CHW'(NCH - 1));
	assign idx      = IW'({chunk_q, pe});

	// Restart at window zero, advance one window per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
		end else if (clear) begin
			chunk_q <= '0;
		end else if (step) begin
			chunk_q <= chunk_q + 1'b1;
		end
	end

endmodule : sba_scan
`default_nettype wire

// File: design/slot_bitmap_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_bitmap_allocator - first-fit allocator over a fixed pool of slots
//
// Command channel: a word is taken at a rising edge with start high and busy
// low. command picks allocate-lowest-free, allocate-named, release-named or
// inspect; slot_id names the slot, now is stored as the allocation stamp.
// Result channel: done is high for one cycle with status, granted_slot,
// slot_taken, slot_stamp, free_count and taken_count valid; the receiver
// takes it at the edge ending that cycle and cannot hold it off. busy is
// low again in that cycle, so the next command may be taken then.
// From acceptance, allocate-lowest-free walks the scan state over the 32-slot
// bitmap windows up to and including the one holding the lowest free slot
// (all ceil(SLOTS/32) of them when none is free), named commands pass the
// read state for the stamp memory read, and an out-of-range id goes straight
// to execute; done and the result word are registered from execute.
// One command is in flight at a time, so a new command is taken only once
// busy is low again.
// Reset clears the taken bitmap and the taken count at once; the stamp memory
// needs no clearing since a stamp is only read from a taken slot.
// ----------------------------------------------------------------------------
module slot_bitmap_allocator #(
	parameter int SLOTS = sba_pkg::SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        command,
	input  wire logic [sba_pkg::ID_W-1:0]          slot_id,
	input  wire logic [sba_pkg::STAMP_W-1:0]       now,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic [sba_pkg::SLOT_OUT_W-1:0]         granted_slot,
	output logic                                   slot_taken,
	output logic [sba_pkg::STAMP_W-1:0]            slot_stamp,
	output logic [sba_pkg::CNT_OUT_W-1:0]          free_count,
	output logic [sba_pkg::CNT_OUT_W-1:0]          taken_count
);
	import sba_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	// Command word held for the whole operation
	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [STAMP_W-1:0] now_q;
	logic               oor_q;
	logic               found_q;
	logic [IW-1:0]      slot_q;

	logic [SLOTS-1:0]   taken_q;
	logic [CW-1:0]      taken_cnt_q;

	logic [STAMP_W-1:0] mem [SLOTS];
	logic [STAMP_W-1:0] rd_q;

	logic               accept;
	logic               id_oor;
	logic               scan_clear;
	logic               scan_step;
	logic               exec;
	scan_t              scan_res;
	logic [IW-1:0]      scan_idx;

	// Execute-step decisions
	logic               cur_taken;
	logic               set_bit;
	logic               clr_bit;
	logic               mem_we;
	logic [STAMP_W-1:0] mem_wd;
	stat_t              res_status;
	logic [SLOT_OUT_W-1:0] res_slot;
	logic               res_flag;
	logic [STAMP_W-1:0] res_stamp;

	stat_t                 status_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic                  flag_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic                  done_q;

	assign accept = start && !busy;
	assign id_oor = ({1'b0, slot_id} >= (ID_W + 1)'(SLOTS));

	sba_scan #(
		.SLOTS (SLOTS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (scan_clear),
		.step     (scan_step),
		.free_map (~taken_q),
		.res      (scan_res),
		.idx      (scan_idx)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (cmd_t'(command) == CMD_ALLOC_NEXT) begin
						state_d = ST_SCAN;
					end else if (id_oor) begin
						state_d = ST_EXEC;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SCAN: begin
				if (scan_res.hit || scan_res.last) begin
					state_d = ST_EXEC;
				end
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		busy       = (state_q != ST_IDLE);
		scan_clear = (state_q == ST_IDLE);
		scan_step  = (state_q == ST_SCAN) && !scan_res.hit && !scan_res.last;
		exec       = (state_q == ST_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the command word and the scan outcome
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd_t'(command);
			id_q   <= slot_id;
			now_q  <= now;
			oor_q  <= id_oor;
			slot_q <= slot_id[IW-1:0];
		end else if (state_q == ST_SCAN) begin
			found_q <= scan_res.hit;
			if (scan_res.hit) begin
				slot_q <= scan_idx;
			end
		end
	end

	// Stamp memory: read in the read state just ahead of execute, write on execute
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= mem[slot_q];
		end
		if (mem_we) begin
			mem[slot_q] <= mem_wd;
		end
	end

	assign cur_taken = taken_q[slot_q];

	// Execute the command on the addressed slot
	always_comb begin
		set_bit    = 1'b0;
		clr_bit    = 1'b0;
		mem_we     = 1'b0;
		mem_wd     = now_q;
		res_status = STAT_DONE;
		res_slot   = id_q[SLOT_OUT_W-1:0];
		res_flag   = 1'b0;
		res_stamp  = '0;
		if (cmd_q == CMD_ALLOC_NEXT) begin
			if (found_q) begin
				set_bit   = exec;
				mem_we    = exec;
				res_slot  = SLOT_OUT_W'(slot_q);
				res_flag  = 1'b1;
				res_stamp = now_q;
			end else begin
				res_status = STAT_NO_FREE;
				res_slot   = '0;
			end
		end else if (oor_q) begin
			res_status = STAT_RANGE;
		end else begin
			unique case (cmd_q)
				CMD_ALLOC_ID: begin
					res_flag = 1'b1;
					if (cur_taken) begin
						res_status = STAT_BAD_STATE;
						res_stamp  = rd_q;
					end else begin
						set_bit   = exec;
						mem_we    = exec;
						res_stamp = now_q;
					end
				end
				CMD_RELEASE: begin
					if (cur_taken) begin
						clr_bit = exec;
						mem_we  = exec;
						mem_wd  = '0;
					end else begin
						res_status = STAT_BAD_STATE;
					end
				end
				CMD_INSPECT: begin
					res_flag  = cur_taken;
					res_stamp = cur_taken ? rd_q : '0;
				end
				default: begin
					res_status = STAT_DONE;
				end
			endcase
		end
	end

	// Update the bitmap and the taken count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= '0;
			taken_cnt_q <= '0;
		end else if (set_bit) begin
			taken_q[slot_q] <= 1'b1;
			taken_cnt_q     <= taken_cnt_q + 1'b1;
		end else if (clr_bit) begin
			taken_q[slot_q] <= 1'b0;
			taken_cnt_q     <= taken_cnt_q - 1'b1;
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= res_status;
			slot_out_q <= res_slot;
			flag_q     <= res_flag;
			stamp_q    <= res_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= exec;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign granted_slot = slot_out_q;
	assign slot_taken   = flag_q;
	assign slot_stamp   = stamp_q;
	assign taken_count  = CNT_OUT_W'(taken_cnt_q);
	assign free_count   = CNT_OUT_W'(SLOTS) - CNT_OUT_W'(taken_cnt_q);

endmodule : slot_bitmap_allocator
`default_nettype wire
